[rtl/tfwm_pkg.sv]
// tfwm_pkg: shared constants and types for the topic filter matcher
// used by tfwm_filter_ctl, tfwm_matcher and the top level; depends on nothing
package tfwm_pkg;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_TOPIC  = 1'b1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // status of the stored filter as seen by the matcher
  typedef struct packed {
    logic overflow;    // bytes were dropped past capacity
    logic tail_plus;   // last stored byte is '+', so the trailing run is open
    logic last_hash;   // last stored byte is '#'
    logic prev_slash;  // byte before the last one is '/'
  } filt_stat_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

endpackage

[rtl/tfwm_ram.sv]
// tfwm_ram: generic single write port, single read port ram, registered read
// write-first on an address collision; no package dependency
module tfwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tfwm_filter_ctl.sv]
// tfwm_filter_ctl: filter loading, length and tail flags, ram write ports
// depends on tfwm_pkg; drives the byte store and the plus-run end table
module tfwm_filter_ctl #(
  parameter int MAX_FILTER_LEN = 64,
  parameter int AW = $clog2(MAX_FILTER_LEN),
  parameter int LW = $clog2(MAX_FILTER_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_en,
  input  logic [7:0]          char_code,
  input  logic                last,
  output logic [LW-1:0]       len,
  output tfwm_pkg::filt_stat_t stat,
  output logic [AW-1:0]       tail_start,
  output logic                st_we,
  output logic [AW-1:0]       st_waddr,
  output logic [7:0]          st_wdata,
  output logic                et_we,
  output logic [AW-1:0]       et_waddr,
  output logic [8+AW-1:0]     et_wdata
);

  logic          open_r, open_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic          tail_plus_r, tail_plus_nxt;
  logic          last_hash_r, last_hash_nxt;
  logic          last_slash_r, last_slash_nxt;
  logic          prev_slash_r, prev_slash_nxt;
  logic [AW-1:0] tail_start_r, tail_start_nxt;

  logic          new_filt;
  logic [LW-1:0] base_len;
  logic          base_tplus;
  logic          room;
  logic          is_plus;

  assign new_filt   = !open_r;
  assign base_len   = new_filt ? '0 : len_r;
  assign base_tplus = new_filt ? 1'b0 : tail_plus_r;
  assign room       = base_len < LW'(MAX_FILTER_LEN);
  assign is_plus    = char_code == tfwm_pkg::CH_PLUS;

  always_comb begin
    open_nxt       = open_r;
    len_nxt        = len_r;
    ovf_nxt        = ovf_r;
    tail_plus_nxt  = tail_plus_r;
    last_hash_nxt  = last_hash_r;
    last_slash_nxt = last_slash_r;
    prev_slash_nxt = prev_slash_r;
    tail_start_nxt = tail_start_r;
    st_we          = 1'b0;
    st_waddr       = base_len[AW-1:0];
    st_wdata       = char_code;
    et_we          = 1'b0;
    et_waddr       = tail_start_r;
    et_wdata       = {char_code, base_len[AW-1:0]};
    if (load_en) begin
      open_nxt = !last;
      ovf_nxt  = (new_filt ? 1'b0 : ovf_r) | !room;
      if (new_filt) begin
        len_nxt        = '0;
        tail_plus_nxt  = 1'b0;
        last_hash_nxt  = 1'b0;
        last_slash_nxt = 1'b0;
        prev_slash_nxt = 1'b0;
      end
      if (room) begin
        st_we          = 1'b1;
        len_nxt        = base_len + LW'(1);
        last_hash_nxt  = char_code == tfwm_pkg::CH_HASH;
        last_slash_nxt = char_code == tfwm_pkg::CH_SLASH;
        prev_slash_nxt = new_filt ? 1'b0 : last_slash_r;
        tail_plus_nxt  = is_plus;
        // a run of '+' starts here
        if (is_plus && !base_tplus) begin
          tail_start_nxt = base_len[AW-1:0];
        end
        // a run of '+' is closed: record where it ends and the byte there
        if (!is_plus && base_tplus) begin
          et_we = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      tail_plus_r  <= 1'b0;
      last_hash_r  <= 1'b0;
      last_slash_r <= 1'b0;
      prev_slash_r <= 1'b0;
      tail_start_r <= '0;
    end else begin
      open_r       <= open_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      tail_plus_r  <= tail_plus_nxt;
      last_hash_r  <= last_hash_nxt;
      last_slash_r <= last_slash_nxt;
      prev_slash_r <= prev_slash_nxt;
      tail_start_r <= tail_start_nxt;
    end
  end

  assign len             = len_r;
  assign tail_start      = tail_start_r;
  assign stat.overflow   = ovf_r;
  assign stat.tail_plus  = tail_plus_r;
  assign stat.last_hash  = last_hash_r;
  assign stat.prev_slash = prev_slash_r;

endmodule

[rtl/tfwm_matcher.sv]
// tfwm_matcher: per-topic matching state, one topic byte per cycle, and result
// depends on tfwm_pkg; reads the byte store and run end table at its position
module tfwm_matcher #(
  parameter int MAX_FILTER_LEN = 64,
  parameter int AW = $clog2(MAX_FILTER_LEN),
  parameter int LW = $clog2(MAX_FILTER_LEN + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 topic_en,
  input  logic                 clear,
  input  logic [7:0]           char_code,
  input  logic [LW-1:0]        len,
  input  tfwm_pkg::filt_stat_t stat,
  input  logic [AW-1:0]        tail_start,
  input  logic [7:0]           q_byte,
  input  logic [8+AW-1:0]      q_end,
  output logic [AW-1:0]        rd_addr,
  output logic                 res_match,
  output logic                 res_err
);

  logic [LW-1:0] pos_r, pos_nxt, pos_a;
  logic          skip_r, skip_nxt, skip_a;
  logic          multi_r, multi_nxt, multi_a;
  logic          mism_r, mism_nxt, mism_a;
  logic          mid_r, mid_nxt, mid_a;
  logic [LW-1:0] rend_idx_r, rend_idx_nxt, rend_idx_a;
  logic [7:0]    rend_byte_r, rend_byte_nxt, rend_byte_a;

  logic          is_slash;
  logic          unterm;
  logic [LW-1:0] cur_idx;
  logic [7:0]    cur_byte;
  logic          tail_ok;

  assign is_slash = char_code == tfwm_pkg::CH_SLASH;

  // end of the '+' run at the current position; an open trailing run ends at len
  assign unterm   = stat.tail_plus && (pos_r == {{(LW-AW){1'b0}}, tail_start});
  assign cur_idx  = mid_r ? rend_idx_r :
                    (unterm ? len : {{(LW-AW){1'b0}}, q_end[AW-1:0]});
  assign cur_byte = mid_r ? rend_byte_r : q_end[8+AW-1:AW];

  always_comb begin
    pos_a       = pos_r;
    skip_a      = skip_r;
    multi_a     = multi_r;
    mism_a      = mism_r;
    mid_a       = mid_r;
    rend_idx_a  = rend_idx_r;
    rend_byte_a = rend_byte_r;
    if (topic_en && !multi_r && !mism_r && (!skip_r || is_slash)) begin
      skip_a = 1'b0;
      if (pos_r >= len) begin
        mism_a = 1'b1;
      end else if (q_byte == tfwm_pkg::CH_PLUS) begin
        if (!is_slash) begin
          pos_a       = pos_r + LW'(1);
          skip_a      = 1'b1;
          mid_a       = 1'b1;
          rend_idx_a  = cur_idx;
          rend_byte_a = cur_byte;
        end else if (cur_idx >= len) begin
          mism_a = 1'b1;
        end else if (cur_byte == tfwm_pkg::CH_HASH) begin
          multi_a = 1'b1;
          pos_a   = cur_idx;
          mid_a   = 1'b0;
        end else if (cur_byte != tfwm_pkg::CH_SLASH) begin
          mism_a = 1'b1;
        end else begin
          // empty levels: the '/' lands on the byte after the whole run
          pos_a = cur_idx + LW'(1);
          mid_a = 1'b0;
        end
      end else if (q_byte == tfwm_pkg::CH_HASH) begin
        multi_a = 1'b1;
      end else if (q_byte != char_code) begin
        mism_a = 1'b1;
      end else begin
        pos_a = pos_r + LW'(1);
        mid_a = 1'b0;
      end
    end
  end

  // rest of filter is empty, "#" or "/#"
  assign tail_ok = (pos_a >= len) ||
                   ((pos_a == len - LW'(1)) && stat.last_hash) ||
                   ((pos_a == len - LW'(2)) && stat.prev_slash && stat.last_hash);

  assign res_err   = stat.overflow || (len == '0);
  assign res_match = !res_err && !mism_a && (multi_a || tail_ok);

  always_comb begin
    if (clear) begin
      pos_nxt       = '0;
      skip_nxt      = 1'b0;
      multi_nxt     = 1'b0;
      mism_nxt      = 1'b0;
      mid_nxt       = 1'b0;
      rend_idx_nxt  = rend_idx_a;
      rend_byte_nxt = rend_byte_a;
    end else begin
      pos_nxt       = pos_a;
      skip_nxt      = skip_a;
      multi_nxt     = multi_a;
      mism_nxt      = mism_a;
      mid_nxt       = mid_a;
      rend_idx_nxt  = rend_idx_a;
      rend_byte_nxt = rend_byte_a;
    end
  end

  assign rd_addr = pos_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      skip_r  <= 1'b0;
      multi_r <= 1'b0;
      mism_r  <= 1'b0;
      mid_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      multi_r <= multi_nxt;
      mism_r  <= mism_nxt;
      mid_r   <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rend_idx_r  <= rend_idx_nxt;
    rend_byte_r <= rend_byte_nxt;
  end

endmodule

[rtl/topic_filter_wildcard_match.sv]
// topic_filter_wildcard_match: top level, input register, matcher, result register
// depends on tfwm_pkg, tfwm_ram, tfwm_filter_ctl and tfwm_matcher
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid in_stall in_cmd in_char_code in_last | in (stall out)
//   result  | out_valid out_stall out_match out_filter_error | out (stall in)
//
// one item per cycle sustained while no result stalls; a result passes the input
// register, then the matcher and result register. the store is read at the next
// position every cycle, which closes the one-byte-per-cycle loop.
// reset is synchronous and clears control state only; no clearing pass.
// a stalled result holds the result register; the item behind it stalls the
// input only if it would produce a result too.
module topic_filter_wildcard_match #(
  parameter int MAX_FILTER_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_char_code,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_match,
  output logic       out_filter_error
);

  localparam int AW = $clog2(MAX_FILTER_LEN);
  localparam int LW = $clog2(MAX_FILTER_LEN + 1);

  tfwm_pkg::in_item_t   item_r;
  logic                 item_v_r, item_v_nxt;
  logic                 res_item;
  logic                 fire;
  logic                 accept;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_match_r, out_err_r;

  logic [LW-1:0]        len;
  tfwm_pkg::filt_stat_t stat;
  logic [AW-1:0]        tail_start;
  logic                 st_we, et_we;
  logic [AW-1:0]        st_waddr, et_waddr;
  logic [7:0]           st_wdata;
  logic [8+AW-1:0]      et_wdata;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           q_byte;
  logic [8+AW-1:0]      q_end;
  logic                 res_match, res_err;

  assign res_item = (item_r.cmd == tfwm_pkg::CMD_TOPIC) && item_r.last;
  assign fire     = item_v_r && (!res_item || !out_valid_r || !out_stall);
  assign in_stall = item_v_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign item_v_nxt    = accept ? 1'b1 : (fire ? 1'b0 : item_v_r);
  assign out_valid_nxt = (fire && res_item) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_v_r    <= item_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{cmd: in_cmd, char_code: in_char_code, last: in_last};
    end
    if (fire && res_item) begin
      out_match_r <= res_match;
      out_err_r   <= res_err;
    end
  end

  tfwm_filter_ctl #(
    .MAX_FILTER_LEN(MAX_FILTER_LEN),
    .AW(AW),
    .LW(LW)
  ) u_filter_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (fire && (item_r.cmd == tfwm_pkg::CMD_FILTER)),
    .char_code (item_r.char_code),
    .last      (item_r.last),
    .len       (len),
    .stat      (stat),
    .tail_start(tail_start),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .et_we     (et_we),
    .et_waddr  (et_waddr),
    .et_wdata  (et_wdata)
  );

  tfwm_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FILTER_LEN)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(rd_addr),
    .rdata(q_byte)
  );

  // per '+' run start: index of the closing byte and the byte itself
  tfwm_ram #(
    .WIDTH(8 + AW),
    .DEPTH(MAX_FILTER_LEN)
  ) u_run_end (
    .clk  (clk),
    .we   (et_we),
    .waddr(et_waddr),
    .wdata(et_wdata),
    .raddr(rd_addr),
    .rdata(q_end)
  );

  tfwm_matcher #(
    .MAX_FILTER_LEN(MAX_FILTER_LEN),
    .AW(AW),
    .LW(LW)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .topic_en  (fire && (item_r.cmd == tfwm_pkg::CMD_TOPIC)),
    .clear     (fire && ((item_r.cmd == tfwm_pkg::CMD_FILTER) || item_r.last)),
    .char_code (item_r.char_code),
    .len       (len),
    .stat      (stat),
    .tail_start(tail_start),
    .q_byte    (q_byte),
    .q_end     (q_end),
    .rd_addr   (rd_addr),
    .res_match (res_match),
    .res_err   (res_err)
  );

  assign out_valid        = out_valid_r;
  assign out_match        = out_match_r;
  assign out_filter_error = out_err_r;

endmodule

[rtl/tfwm_checker.sv]
// tfwm_checker: port-level assertions for the topic filter matcher, and its bind
// depends only on the ports of topic_filter_wildcard_match
module tfwm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic [7:0] in_char_code,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_match,
  input logic       out_filter_error
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match) && $stable(out_filter_error))
    else $error("result changed while stalled");

  // a stalled item stays put on the input side
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_char_code) &&
                            $stable(in_last))
    else $error("input item changed while stalled");

  a_err_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_filter_error |-> !out_match)
    else $error("match with filter error");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

endmodule

bind topic_filter_wildcard_match tfwm_checker u_tfwm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_cmd          (in_cmd),
  .in_char_code    (in_char_code),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_match       (out_match),
  .out_filter_error(out_filter_error)
);

[dv/testbench.sv]
// testbench for topic_filter_wildcard_match: loads filters, streams topics, checks each
// verdict against an in-file model or the script; depends on tfwm_pkg and the rtl top
module testbench;

  localparam int MAX_FILTER_LEN = 64;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 500;

  typedef struct packed {
    logic match;
    logic ferr;
  } verdict_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       last;
    logic [6:0] reps;
    logic       fixed;
    verdict_t   want;
  } step_row_t;

  typedef logic [7:0] text_t [$];

  localparam verdict_t V_NONE  = '{1'b0, 1'b0};
  localparam verdict_t V_HIT   = '{1'b1, 1'b0};
  localparam verdict_t V_ERROR = '{1'b0, 1'b1};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = tfwm_pkg::CMD_FILTER;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_match;
  logic       out_filter_error;

  topic_filter_wildcard_match #(
    .MAX_FILTER_LEN(MAX_FILTER_LEN)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_char_code    (in_char_code),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match       (out_match),
    .out_filter_error(out_filter_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // matcher model state
  logic [7:0] filt_bytes [MAX_FILTER_LEN];
  int         filt_len = 0;
  bit         filt_ovf = 1'b0;
  bit         filt_open = 1'b0;
  int         filt_pos = 0;
  bit         skip_lvl = 1'b0;
  bit         hash_hit = 1'b0;
  bit         miss_seen = 1'b0;

  verdict_t   due_verdicts [$];
  verdict_t   head;
  int         n_err = 0;
  int         n_sent = 0;
  int         n_cycles = 0;
  bit         calm = 1'b0;
  int         stall_left = 0;

  function automatic void clear_walk();
    filt_pos  = 0;
    skip_lvl  = 1'b0;
    hash_hit  = 1'b0;
    miss_seen = 1'b0;
  endfunction

  function automatic void walk_topic_byte(input logic [7:0] ch);
    bit done;
    done = 1'b0;
    if (hash_hit || miss_seen) return;
    if (skip_lvl) begin
      if (ch != tfwm_pkg::CH_SLASH) return;
      skip_lvl = 1'b0;
    end
    while (!done) begin
      if (filt_pos >= filt_len) begin
        miss_seen = 1'b1;
        done = 1'b1;
      end else if (filt_bytes[filt_pos] == tfwm_pkg::CH_PLUS) begin
        filt_pos++;
        // a '/' right here means an empty level, so it meets the next filter byte
        if (ch != tfwm_pkg::CH_SLASH) begin
          skip_lvl = 1'b1;
          done = 1'b1;
        end
      end else if (filt_bytes[filt_pos] == tfwm_pkg::CH_HASH) begin
        hash_hit = 1'b1;
        done = 1'b1;
      end else begin
        if (filt_bytes[filt_pos] != ch) miss_seen = 1'b1;
        else filt_pos++;
        done = 1'b1;
      end
    end
  endfunction

  // rest of the filter may only be nothing, "#" or "/#"
  function automatic bit tail_ok();
    if (filt_pos >= filt_len) return 1'b1;
    if (filt_len - filt_pos == 1) return filt_bytes[filt_pos] == tfwm_pkg::CH_HASH;
    if (filt_len - filt_pos == 2)
      return filt_bytes[filt_pos] == tfwm_pkg::CH_SLASH &&
             filt_bytes[filt_pos + 1] == tfwm_pkg::CH_HASH;
    return 1'b0;
  endfunction

  function automatic void predict_item(input logic cmd, input logic [7:0] ch,
                                       input logic last, output bit emits,
                                       output verdict_t v);
    emits = 1'b0;
    v = V_NONE;
    if (cmd == tfwm_pkg::CMD_FILTER) begin
      clear_walk();
      if (!filt_open) begin
        filt_len  = 0;
        filt_ovf  = 1'b0;
        filt_open = 1'b1;
      end
      if (filt_len < MAX_FILTER_LEN) begin
        filt_bytes[filt_len] = ch;
        filt_len++;
      end else begin
        filt_ovf = 1'b1;
      end
      if (last) filt_open = 1'b0;
    end else begin
      walk_topic_byte(ch);
      if (last) begin
        emits = 1'b1;
        v.ferr  = filt_ovf || filt_len == 0;
        v.match = !v.ferr && !miss_seen && (hash_hit || tail_ok());
        clear_walk();
      end
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic last,
                           input bit fixed, input verdict_t want);
    bit       emits;
    verdict_t v;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_char_code <= ch;
    in_last      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(cmd, ch, last, emits, v);
    if (emits) due_verdicts.push_back(fixed ? want : v);
    n_sent++;
  endtask

  task automatic send_text(input logic cmd, input text_t s, input bit close);
    for (int i = 0; i < s.size(); i++)
      send_item(cmd, s[i], close && i == s.size() - 1, 1'b0, V_NONE);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  function automatic text_t make_filter();
    text_t f;
    int    n_lvl;
    n_lvl = $urandom_range(1, 4);
    // now and then a filter around the store capacity, up to two bytes either side
    if ($urandom_range(0, 24) == 0) begin
      repeat ($urandom_range(MAX_FILTER_LEN - 2, MAX_FILTER_LEN + 2))
        f.push_back($urandom_range(0, 5) == 0 ? tfwm_pkg::CH_SLASH : word_char());
      return f;
    end
    if ($urandom_range(0, 5) == 0) f.push_back(tfwm_pkg::CH_SLASH);
    for (int i = 0; i < n_lvl; i++) begin
      if (i != 0) f.push_back(tfwm_pkg::CH_SLASH);
      case ($urandom_range(0, 9))
        0, 1: f.push_back(tfwm_pkg::CH_PLUS);
        2: begin
          f.push_back(tfwm_pkg::CH_HASH);
          return f;
        end
        3: begin
          // wildcard sharing a level with ordinary bytes
          f.push_back(word_char());
          f.push_back($urandom_range(0, 1) ? tfwm_pkg::CH_PLUS : tfwm_pkg::CH_HASH);
        end
        default: repeat ($urandom_range(1, 3)) f.push_back(word_char());
      endcase
    end
    if ($urandom_range(0, 5) == 0) f.push_back(tfwm_pkg::CH_SLASH);
    return f;
  endfunction

  function automatic text_t make_topic(input text_t f);
    text_t t;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6))
        t.push_back($urandom_range(0, 3) == 0 ? tfwm_pkg::CH_SLASH : word_char());
      return t;
    end
    for (int i = 0; i < f.size(); i++) begin
      if (f[i] == tfwm_pkg::CH_PLUS) begin
        repeat ($urandom_range(0, 2)) t.push_back(word_char());
      end else if (f[i] == tfwm_pkg::CH_HASH) begin
        repeat ($urandom_range(0, 4))
          t.push_back($urandom_range(0, 2) == 0 ? tfwm_pkg::CH_SLASH : word_char());
        break;
      end else if (f[i] == tfwm_pkg::CH_SLASH && i == f.size() - 2 &&
                   f[i + 1] == tfwm_pkg::CH_HASH && $urandom_range(0, 2) == 0) begin
        // parent level of a "/#" filter
        break;
      end else begin
        t.push_back(f[i]);
      end
    end
    if (t.size() != 0 && $urandom_range(0, 4) == 0)
      t[$urandom_range(0, t.size() - 1)] = word_char();
    if ($urandom_range(0, 9) == 0) t.push_back(word_char());
    if (t.size() == 0) t.push_back(tfwm_pkg::CH_SLASH);
    return t;
  endfunction

  // result side: stall in random bursts
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_verdicts.size() == 0) begin
        $display("%0t: result with no item pending, match=%0b filter_error=%0b",
                 $time, out_match, out_filter_error);
        n_err++;
      end else begin
        head = due_verdicts.pop_front();
        if (out_match !== head.match) begin
          $display("%0t: match expected %0b actual %0b", $time, head.match, out_match);
          n_err++;
        end
        if (out_filter_error !== head.ferr) begin
          $display("%0t: filter_error expected %0b actual %0b",
                   $time, head.ferr, out_filter_error);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  step_row_t script [24];

  initial begin : stimulus
    text_t cur_filter;
    text_t nf;
    int    k;
    int    rand_start;
    bit    drained;
    drained = 1'b0;
    script = '{
      // topic before any filter: empty filter
      '{tfwm_pkg::CMD_TOPIC,  "x",                1'b1, 7'd1,  1'b1, V_ERROR},
      // "a/#" also matches its parent level
      '{tfwm_pkg::CMD_FILTER, "a",                1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_SLASH, 1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_HASH,  1'b1, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  "a",                1'b1, 7'd1,  1'b0, V_NONE},
      // "+/<ff>": empty and non-empty first level
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_PLUS,  1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_SLASH, 1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, 8'hFF,              1'b1, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  tfwm_pkg::CH_SLASH, 1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  8'hFF,              1'b1, 7'd1,  1'b1, V_HIT},
      '{tfwm_pkg::CMD_TOPIC,  8'h00,              1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  tfwm_pkg::CH_SLASH, 1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  8'hFF,              1'b1, 7'd1,  1'b1, V_HIT},
      // topic longer than the filter
      '{tfwm_pkg::CMD_TOPIC,  tfwm_pkg::CH_SLASH, 1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  8'hFF,              1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  tfwm_pkg::CH_SLASH, 1'b1, 7'd1,  1'b0, V_NONE},
      // topic against an unfinished filter, then a topic cut short by a filter byte
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_PLUS,  1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  "q",                1'b1, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  "z",                1'b0, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, tfwm_pkg::CH_HASH,  1'b1, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  "a",                1'b1, 7'd1,  1'b0, V_NONE},
      // one byte past capacity
      '{tfwm_pkg::CMD_FILTER, "a",                1'b0, 7'd64, 1'b0, V_NONE},
      '{tfwm_pkg::CMD_FILTER, 8'hFF,              1'b1, 7'd1,  1'b0, V_NONE},
      '{tfwm_pkg::CMD_TOPIC,  8'h00,              1'b1, 7'd1,  1'b1, V_ERROR}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r])
      repeat (script[r].reps)
        send_item(script[r].cmd, script[r].ch, script[r].last, script[r].fixed, script[r].want);

    rand_start = n_sent;
    cur_filter = make_filter();
    while (n_sent < rand_start + RANDOM_ITEMS) begin
      if (!drained && n_sent > rand_start + RANDOM_ITEMS / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      if (n_sent > rand_start + RANDOM_ITEMS - 100) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 8))
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, V_NONE);
        end
        1: begin
          // filter left open while topics run, topics possibly abandoned
          nf = make_filter();
          k = $urandom_range(1, nf.size());
          send_text(tfwm_pkg::CMD_FILTER, nf[0:k-1], 1'b0);
          send_text(tfwm_pkg::CMD_TOPIC, make_topic(nf), 1'($urandom_range(0, 1)));
          send_item(tfwm_pkg::CMD_FILTER,
                    $urandom_range(0, 1) ? tfwm_pkg::CH_HASH : word_char(), 1'b1,
                    1'b0, V_NONE);
        end
        default: begin
          cur_filter = make_filter();
          send_text(tfwm_pkg::CMD_FILTER, cur_filter, 1'b1);
          repeat ($urandom_range(1, 5))
            send_text(tfwm_pkg::CMD_TOPIC, make_topic(cur_filter), 1'b1);
        end
      endcase
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (n_err == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
